// File: hw/rtl/sort_then_binary_search_table_assert.svh
// assertion macros shared by the table rtl
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef SORT_THEN_BINARY_SEARCH_TABLE_ASSERT_SVH
`define SORT_THEN_BINARY_SEARCH_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STBS_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define STBS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: hw/rtl/stbs_pkg.sv
// shared types for the sorted lookup table
// no dependencies
`timescale 1ns / 1ps

package stbs_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 8;

    // request kinds carried on s_tuser
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_INIT,
        ST_PICK,
        ST_SCAN,
        ST_SWAP_P,
        ST_SWAP_LO,
        ST_SRCH_CHK,
        ST_SRCH_CMP,
        ST_DONE
    } stbs_state_t;

    // comparator flags: a < b and a == b
    typedef struct packed {
        logic lt;
        logic eq;
    } stbs_cmp_t;

endpackage

// File: hw/rtl/sort_then_binary_search_table.sv
// Sorted lookup table. Load transactions (s_tuser = 0) append a signed 32-bit value; a
// load with s_tlast closes the set and the table is then sorted ascending by selection
// sort, using the single read port of the table and the one comparator that scans it.
// A search transaction (s_tuser = 1) does a binary search, one table read and one compare
// per probe, and returns one result transaction. The first load after a closed set starts
// a new set; loads beyond DEPTH entries are dropped. s_tready is low while a sort or
// search runs; the result register lets a new transaction in while the previous result
// still waits on m_tready.
// depends on stbs_pkg, stbs_cmp and sort_then_binary_search_table_assert.svh
`timescale 1ns / 1ps

`include "sort_then_binary_search_table_assert.svh"

module sort_then_binary_search_table
    import stbs_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value [31:0]
    input  logic        s_tuser,   // req_type [0]
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // found [0], position [8:1], zero [15:9]
);

    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

    // table storage
    logic signed [DATA_W-1:0] mem [DEPTH];
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;
    logic signed [DATA_W-1:0] rd_data_reg;

    // sequencer state
    stbs_state_t              state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     closed_reg, closed_next;
    logic [ADDR_W-1:0]        p_reg, p_next;
    logic [CNT_W-1:0]         q_reg, q_next;
    logic [ADDR_W-1:0]        lo_reg, lo_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] pval_reg, pval_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]         bl_reg, bl_next;
    logic [CNT_W-1:0]         bh_reg, bh_next;
    logic [ADDR_W-1:0]        mid_reg, mid_next;
    logic                     found_reg, found_next;

    // result register
    logic                     m_valid_reg, m_valid_next;
    logic                     m_found_reg, m_found_next;
    logic [POS_W-1:0]         m_pos_reg, m_pos_next;

    // helpers
    logic                     s_acc;
    logic [CNT_W-1:0]         q_prev;
    logic [CNT_W-1:0]         p_plus1;
    logic [CNT_W:0]           mid_sum;
    logic [ADDR_W+POS_W-1:0]  mid_wide;
    logic signed [DATA_W-1:0] cmp_b;
    stbs_cmp_t                cmp;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign q_prev   = q_reg - CNT_W'(1);
    assign p_plus1  = CNT_W'(p_reg) + CNT_W'(1);
    assign mid_sum  = {1'b0, bl_reg} + {1'b0, bh_reg} - (CNT_W + 1)'(1);
    assign mid_wide = {{POS_W{1'b0}}, mid_reg};
    assign cmp_b    = (state_reg == ST_SRCH_CMP) ? key_reg : min_reg;

    // the one comparator, shared by sort and search
    stbs_cmp u_cmp (
        .a   (rd_data_reg),
        .b   (cmp_b),
        .res (cmp)
    );

    // table write port and registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            closed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            closed_reg  <= closed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        q_reg       <= q_next;
        lo_reg      <= lo_next;
        min_reg     <= min_next;
        pval_reg    <= pval_next;
        key_reg     <= key_next;
        bl_reg      <= bl_next;
        bh_reg      <= bh_next;
        mid_reg     <= mid_next;
        found_reg   <= found_next;
        m_found_reg <= m_found_next;
        m_pos_reg   <= m_pos_next;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        closed_next  = closed_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        lo_next      = lo_reg;
        min_next     = min_reg;
        pval_next    = pval_reg;
        key_next     = key_reg;
        bl_next      = bl_reg;
        bh_next      = bh_reg;
        mid_next     = mid_reg;
        found_next   = found_reg;
        m_found_next = m_found_reg;
        m_pos_next   = m_pos_reg;
        m_valid_next = m_valid_reg && !m_tready;
        mem_we       = 1'b0;
        mem_waddr    = count_reg[ADDR_W-1:0];
        mem_wdata    = s_tdata;
        mem_raddr    = p_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == REQ_LOAD) begin
                        // a closed set restarts at entry zero
                        if (closed_reg) begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            count_next = CNT_W'(1);
                        end else if (count_reg < CNT_W'(DEPTH)) begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        closed_next = s_tlast;
                        if (s_tlast) begin
                            state_next = ST_SORT_INIT;
                        end
                    end else begin
                        key_next   = s_tdata;
                        bl_next    = '0;
                        bh_next    = count_reg;
                        state_next = ST_SRCH_CHK;
                    end
                end
            end
            ST_SORT_INIT: begin
                p_next = '0;
                if (count_reg < CNT_W'(2)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                // fetch the entry at the current sorted position
                mem_raddr  = p_reg;
                q_next     = p_plus1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // read data belongs to index q-1, one read issued per cycle
                mem_raddr = q_reg[ADDR_W-1:0];
                if (q_reg == p_plus1) begin
                    pval_next = rd_data_reg;
                    min_next  = rd_data_reg;
                    lo_next   = p_reg;
                end else if (cmp.lt) begin
                    min_next = rd_data_reg;
                    lo_next  = q_prev[ADDR_W-1:0];
                end
                if (q_reg == count_reg) begin
                    state_next = ST_SWAP_P;
                end else begin
                    q_next = q_reg + CNT_W'(1);
                end
            end
            ST_SWAP_P: begin
                mem_we     = 1'b1;
                mem_waddr  = p_reg;
                mem_wdata  = min_reg;
                state_next = ST_SWAP_LO;
            end
            ST_SWAP_LO: begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg;
                mem_wdata = pval_reg;
                p_next    = p_reg + ADDR_W'(1);
                if (CNT_W'(p_reg) + CNT_W'(2) < count_reg) begin
                    state_next = ST_PICK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH_CHK: begin
                // probe the midpoint while the window is not empty
                mid_next  = mid_sum[ADDR_W:1];
                mem_raddr = mid_sum[ADDR_W:1];
                if (bl_reg < bh_reg) begin
                    state_next = ST_SRCH_CMP;
                end else begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_SRCH_CMP: begin
                if (cmp.eq) begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else if (!cmp.lt) begin
                    bh_next    = CNT_W'(mid_reg);
                    state_next = ST_SRCH_CHK;
                end else begin
                    bl_next    = CNT_W'(mid_reg) + CNT_W'(1);
                    state_next = ST_SRCH_CHK;
                end
            end
            ST_DONE: begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_pos_next   = found_reg ? mid_wide[POS_W-1:0] : {POS_W{1'b1}};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_pos_reg, m_found_reg};

    // checks on the sequencer
    `STBS_ASSERT_IMPL(a_count_range, 1'b1, count_reg <= CNT_W'(DEPTH),
        "entry count beyond table depth")
    `STBS_ASSERT_IMPL(a_pick_range, state_reg == ST_PICK, p_plus1 < count_reg,
        "sort position past the last pair")
    `STBS_ASSERT_IMPL(a_scan_min, state_reg == ST_SWAP_P, CNT_W'(lo_reg) < count_reg,
        "selected minimum outside the loaded entries")
    `STBS_ASSERT_NEXT(a_probe_range, state_reg == ST_SRCH_CHK && bl_reg < bh_reg,
        CNT_W'(mid_reg) < count_reg, "search probe outside the loaded entries")

endmodule

// File: hw/rtl/stbs_cmp.sv
// shared signed comparator used by both sort scan and binary search
// depends on stbs_pkg
`timescale 1ns / 1ps

module stbs_cmp
    import stbs_pkg::*;
(
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output stbs_cmp_t                res
);

    // one signed magnitude compare and one equality
    always_comb begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule
